@@ design/amfmw_pkg.sv @@
// Shared constants, codes and a helper function for the audio mixer with FIFO and mute watchdog.
package amfmw_pkg;

  localparam int FifoDepth   = 1024;
  localparam int MaxChannels = 4;
  localparam int MaxRead     = 64;

  localparam int AddrW = $clog2(FifoDepth);
  localparam int FillW = $clog2(FifoDepth + 1);
  localparam int WideW = AddrW + 2;
  localparam int RemW  = $clog2(MaxRead + 1);
  localparam int ChanN = (MaxChannels < 4) ? MaxChannels : 4;
  localparam int SumW  = 18;

  localparam logic signed [SumW-1:0] SumPosLim = 18'sd32768;
  localparam logic signed [SumW-1:0] SumNegLim = -18'sd32768;
  localparam logic signed [15:0]     PcmMax    = 16'sd32767;
  localparam logic signed [15:0]     PcmMin    = -16'sd32768;

  localparam logic [2:0]  ActiveRst = 3'd1;
  localparam logic [10:0] LimitRst  = 11'd1024;
  localparam logic [31:0] ThreshRst = 32'd3000;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MUTE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_LIMIT  = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_e;

  function automatic logic [AddrW-1:0] wrap_inc(logic [AddrW-1:0] idx);
    if (idx == AddrW'(FifoDepth - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

endpackage

@@ design/amfmw_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
interface amfmw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] chan_a;
  logic signed [15:0] chan_b;
  logic signed [15:0] chan_c;
  logic signed [15:0] chan_d;
  logic               quantum_end;
  logic [6:0]         read_count;

  modport source (output valid, func, chan_a, chan_b, chan_c, chan_d, quantum_end,
                  read_count, input ready);
  modport sink (input valid, func, chan_a, chan_b, chan_c, chan_d, quantum_end,
                read_count, output ready);
endinterface

interface amfmw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, pcm_sample, status, last, input ready);
  modport sink (input valid, pcm_sample, status, last, output ready);
endinterface

interface amfmw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/audio_mixer_fifo_mute_watchdog_core.sv @@
// Audio mixer with a sample FIFO in a synchronous memory and a mute watchdog.
//
// Channels: in_i carries push, tick and read beats; out_o returns the results
// of read beats; cfg_i writes the active channel count, the FIFO limit and the
// mute threshold, and is always ready.
// Push and tick beats can be accepted one per cycle while no read is in progress.
// A push writes its mixed sample to the memory at the tail in that same cycle.
// A read beat keeps in_i not ready until all its results are issued; the
// single memory read port fetches one sample a cycle while the staging
// register is free, and a status-only read issues one result. Results
// reach out_o one per cycle while the receiver accepts them.
// A read staging register and the output register sit between the memory and
// out_o, so pushes and ticks are still accepted while a result waits. When the
// receiver stalls, fetching stops once both registers are full; nothing is lost.
// Reset empties the FIFO, returns the watchdog to its initial phase and loads
// the register reset values. The memory contents are not cleared: only entries
// that were written are ever read.
module audio_mixer_fifo_mute_watchdog_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  amfmw_cfg_if.sink  cfg_i,
  amfmw_in_if.sink   in_i,
  amfmw_out_if.source out_o
);
  import amfmw_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_e;
  typedef enum logic [1:0] {PH_INITIAL, PH_MUTED, PH_SOUND} phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [2:0]         active_q;
  logic [10:0]        limit_q;
  logic [31:0]        thresh_q;
  logic [AddrW-1:0]   head_q, tail_q;
  logic [FillW-1:0]   fill_q;
  logic [31:0]        ticks_q;
  logic               qsilent_q;
  logic [RemW-1:0]    rem_q;
  status_e            kind_q;
  logic               s1_valid_q, out_valid_q;
  status_e            s1_status_q, out_status_q;
  logic               s1_last_q, out_last_q;
  logic signed [15:0] out_pcm_q;
  logic [15:0]        rdata_q;
  logic [15:0]        mem [FifoDepth];

  logic               in_fire, cfg_fire, mem_we, rd_en, issue, out_load, s1_free;
  logic signed [15:0] chans [4];
  logic [2:0]         n_eff;
  logic signed [SumW-1:0] sum;
  logic               any_sound, qs_next, mute_err;
  logic signed [15:0] pcm;
  logic [FillW-1:0]   fill_inc, lim, drop, fill_push;
  logic [AddrW-1:0]   head_a, head_push;
  logic [WideW-1:0]   head_sum;
  logic [RemW-1:0]    req, cnt;

  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);

  assign chans[0] = in_i.chan_a;
  assign chans[1] = in_i.chan_b;
  assign chans[2] = in_i.chan_c;
  assign chans[3] = in_i.chan_d;

  // Mix the active channels and convert the Q1.15 sum to PCM.
  always_comb begin
    n_eff = (active_q > 3'(ChanN)) ? 3'(ChanN) : active_q;
    sum = '0;
    any_sound = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (k < int'(n_eff)) begin
        sum = sum + SumW'(chans[k]);
        any_sound = any_sound | (chans[k] != 16'sd0);
      end
    end
    if (sum == '0) begin
      pcm = '0;
    end else if (sum > 0) begin
      pcm = (sum >= SumPosLim) ? PcmMax : 16'(sum - 1'b1);
    end else begin
      pcm = (sum < SumNegLim) ? PcmMin : 16'(sum);
    end
    qs_next = qsilent_q & ~any_sound;
  end

  // FIFO pointers after a push: a full store overwrites its oldest entry, and
  // everything above the limit is dropped from the head in one step.
  always_comb begin
    if (fill_q < FillW'(FifoDepth)) begin
      fill_inc = fill_q + 1'b1;
      head_a   = head_q;
    end else begin
      fill_inc = fill_q;
      head_a   = wrap_inc(head_q);
    end
    if (32'(limit_q) > 32'(FifoDepth)) begin
      lim = FillW'(FifoDepth);
    end else begin
      lim = FillW'(limit_q);
    end
    drop      = '0;
    fill_push = fill_inc;
    if (fill_inc > lim) begin
      drop      = fill_inc - lim;
      fill_push = lim;
    end
    head_sum = WideW'(head_a) + WideW'(drop);
    if (head_sum >= WideW'(FifoDepth)) begin
      head_sum = head_sum - WideW'(FifoDepth);
    end
    head_push = AddrW'(head_sum);
  end

  always_comb begin
    if (32'(in_i.read_count) > 32'(MaxRead)) begin
      req = RemW'(MaxRead);
    end else begin
      req = RemW'(in_i.read_count);
    end
    cnt = (32'(req) < 32'(fill_q)) ? req : RemW'(fill_q);
    mute_err = (phase_q == PH_MUTED) && (ticks_q > thresh_q);
  end

  assign out_load = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_free  = !s1_valid_q || out_load;
  assign issue    = (state_q == S_READ) && s1_free;
  assign rd_en    = issue && (kind_q == ST_OK);
  assign mem_we   = in_fire && (in_i.func == FUNC_PUSH) && (n_eff != 3'd0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= pcm;
    end
    if (rd_en) begin
      rdata_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_INITIAL;
      active_q    <= ActiveRst;
      limit_q     <= LimitRst;
      thresh_q    <= ThreshRst;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      ticks_q     <= '0;
      qsilent_q   <= 1'b1;
      rem_q       <= '0;
      kind_q      <= ST_OK;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_i.index)
          REG_ACTIVE: active_q <= cfg_i.data[2:0];
          REG_LIMIT:  limit_q  <= cfg_i.data[10:0];
          REG_THRESH: thresh_q <= cfg_i.data;
          default: ;
        endcase
      end

      if (in_fire) begin
        case (in_i.func)
          FUNC_PUSH: begin
            if (n_eff != 3'd0) begin
              tail_q <= wrap_inc(tail_q);
              fill_q <= fill_push;
              head_q <= head_push;
              if (in_i.quantum_end) begin
                if (qs_next) begin
                  if (phase_q == PH_INITIAL) begin
                    phase_q <= PH_MUTED;
                    ticks_q <= '0;
                  end
                end else begin
                  phase_q <= PH_SOUND;
                end
                qsilent_q <= 1'b1;
              end else begin
                qsilent_q <= qs_next;
              end
            end
          end
          FUNC_TICK: begin
            if (phase_q == PH_MUTED && ticks_q != '1) begin
              ticks_q <= ticks_q + 1'b1;
            end
          end
          FUNC_READ: begin
            state_q <= S_READ;
            if (mute_err) begin
              kind_q <= ST_MUTE;
              rem_q  <= RemW'(1);
            end else if (cnt == '0) begin
              kind_q <= ST_EMPTY;
              rem_q  <= RemW'(1);
            end else begin
              kind_q <= ST_OK;
              rem_q  <= cnt;
            end
          end
          default: ;
        endcase
      end

      // Each issue moves one result into the staging register; data results
      // pop the head entry, whose word arrives from memory in the next cycle.
      if (issue) begin
        s1_valid_q <= 1'b1;
        rem_q      <= rem_q - 1'b1;
        if (kind_q == ST_OK) begin
          head_q <= wrap_inc(head_q);
          fill_q <= fill_q - 1'b1;
        end
        if (rem_q == RemW'(1)) begin
          state_q <= S_IDLE;
        end
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_status_q <= kind_q;
      s1_last_q   <= (rem_q == RemW'(1));
    end
    if (out_load) begin
      out_status_q <= s1_status_q;
      out_last_q   <= s1_last_q;
      out_pcm_q    <= (s1_status_q == ST_OK) ? rdata_q : 16'sd0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pcm_sample = out_pcm_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

endmodule

@@ design/amfmw_checker.sv @@
// Port-level assertions for the mixer core, attached by a bind statement.
module amfmw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [1:0]        in_func_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [15:0] out_pcm_i,
  input logic [1:0]        out_status_i,
  input logic              out_last_i
);
  import amfmw_pkg::*;

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pcm_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // Status results end their read and carry no sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_last_i && out_pcm_i == 16'sd0)
    else $error("status result without last or with a sample");

  // A read leaves the input side busy in the cycle after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FUNC_READ |=> !in_ready_i)
    else $error("input accepted right after a read");

  // The status code is never the unused value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == ST_OK || out_status_i == ST_EMPTY
      || out_status_i == ST_MUTE)
    else $error("undefined status code");

endmodule

bind audio_mixer_fifo_mute_watchdog_core amfmw_checker u_amfmw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_pcm_i    (out_o.pcm_sample),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);
